// ===== sv/icpd_pkg.sv =====
// ----------------------------------------------------------------------------
// icpd_pkg
// shared widths, state codes and result type of the lehmer code decoder
// ----------------------------------------------------------------------------
package icpd_pkg;

    localparam int RANK_W  = 10;
    localparam int ELEM_W  = 11;
    localparam int LEN_W   = 11;
    // epoch tag kept next to each tree entry, a wrap forces a clearing sweep
    localparam int EPOCH_W = 6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DESC,
        ST_DCHK,
        ST_REM,
        ST_OUT
    } icpd_state_t;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              last;
        logic              bad_rank;
    } result_t;

endpackage

// ===== sv/icpd_in_if.sv =====
// ----------------------------------------------------------------------------
// icpd_in_if
// input channel: one lehmer digit per beat with its start flag
// ----------------------------------------------------------------------------
interface icpd_in_if;

    logic                        valid;
    logic                        ready;
    logic                        start_req;
    logic [icpd_pkg::RANK_W-1:0] rank;

    modport source (output valid, output start_req, output rank, input ready);
    modport sink (input valid, input start_req, input rank, output ready);

endinterface

// ===== sv/icpd_out_if.sv =====
// ----------------------------------------------------------------------------
// icpd_out_if
// output channel: one permutation element per beat
// ----------------------------------------------------------------------------
interface icpd_out_if;

    logic                        valid;
    logic                        ready;
    logic [icpd_pkg::ELEM_W-1:0] element;
    logic                        last;
    logic                        bad_rank;

    modport source (output valid, output element, output last, output bad_rank,
                    input ready);
    modport sink (input valid, input element, input last, input bad_rank,
                  output ready);

endinterface

// ===== sv/icpd_tree_ram.sv =====
// ----------------------------------------------------------------------------
// icpd_tree_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module icpd_tree_ram #(
    parameter int DEPTH = 1024,
    parameter int DW    = 17,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/icpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// icpd_ctrl
// sequencer: clearing sweep, binary lifting descent and fenwick removal
// ----------------------------------------------------------------------------
module icpd_ctrl #(
    parameter int MAX_LENGTH = 1024,
    localparam int AW        = $clog2(MAX_LENGTH),
    localparam int LW        = $clog2(MAX_LENGTH + 1),
    localparam int DW        = icpd_pkg::EPOCH_W + LW
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [icpd_pkg::LEN_W-1:0]  perm_length,
    icpd_in_if.sink                     din,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [DW-1:0]               mem_wdata,
    output logic [AW-1:0]               mem_raddr,
    input  logic [DW-1:0]               mem_rdata,
    output logic                        res_valid,
    output icpd_pkg::result_t           res,
    input  logic                        res_free
);

    localparam int EPW    = icpd_pkg::EPOCH_W;
    localparam int LENW   = icpd_pkg::LEN_W;
    localparam int RW     = icpd_pkg::RANK_W;
    localparam int ELW    = icpd_pkg::ELEM_W;
    localparam int NW     = (LW > LENW) ? LW : LENW;
    localparam int CW     = ((LW + 1) > RW) ? (LW + 1) : RW;

    localparam logic [NW-1:0]  MAX_N     = NW'(MAX_LENGTH);
    localparam logic [LW:0]    MAX_V     = (LW + 1)'(MAX_LENGTH);
    localparam logic [LW-1:0]  MAX_L     = LW'(MAX_LENGTH);
    localparam logic [LW-1:0]  TOP_STEP  = {1'b1, {(LW - 1){1'b0}}};
    localparam logic [AW-1:0]  LAST_ADDR = AW'(MAX_LENGTH - 1);
    localparam logic [EPW-1:0] EPOCH_MAX = '1;

    icpd_pkg::icpd_state_t state_reg, state_next;

    logic [EPW-1:0]  epoch_reg, epoch_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic            go_reg, go_next;
    logic [LENW-1:0] pos_reg, pos_next;

    logic [RW-1:0]   rank_reg, rank_next;
    logic [LW-1:0]   n_reg, n_next;
    logic [LW-1:0]   x_reg, x_next;
    logic [LW-1:0]   acc_reg, acc_next;
    logic [LW-1:0]   step_reg, step_next;
    logic [LW:0]     v_reg, v_next;
    icpd_pkg::result_t res_reg, res_next;

    logic [LW-1:0]   eff_n;
    logic [LW-1:0]   nx;
    logic [EPW-1:0]  rd_tag;
    logic [LW-1:0]   rd_cnt;
    logic [LW-1:0]   rd_idx;
    logic [LW-1:0]   rd_low;
    logic [LW-1:0]   rd_val;
    logic [CW-1:0]   sum;
    logic            take;
    logic [LW:0]     v_cand;
    logic            v_bad;
    logic [LW:0]     v_low;
    logic [LW:0]     v_step;
    logic [LENW-1:0] pos_inc;
    logic            is_last;
    logic [LW-1:0]   clr_idx;
    logic [LW-1:0]   clr_low;

    // lengths above the tree size saturate
    assign eff_n = (NW'(perm_length) > MAX_N) ? MAX_L : LW'(perm_length);

    assign nx     = x_reg | step_reg;
    assign rd_tag = mem_rdata[DW-1 -: EPW];
    assign rd_cnt = mem_rdata[LW-1:0];
    assign rd_idx = (state_reg == icpd_pkg::ST_REM) ? v_reg[LW-1:0] : nx;
    assign rd_low = rd_idx & (~rd_idx + 1'b1);
    // an entry from an older epoch reads as all values present
    assign rd_val = (rd_tag == epoch_reg) ? rd_cnt : rd_low;

    assign sum  = CW'(acc_reg) + CW'(rd_val);
    assign take = (sum <= CW'(rank_reg));

    assign v_cand = {1'b0, x_reg} + (LW + 1)'(1);
    assign v_bad  = (v_cand > {1'b0, n_reg});
    assign v_low  = v_reg & (~v_reg + 1'b1);
    assign v_step = v_reg + v_low;

    assign pos_inc = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
    assign is_last = (NW'(pos_inc) == NW'(n_reg));

    assign clr_idx = LW'(clr_addr_reg) + 1'b1;
    assign clr_low = clr_idx & (~clr_idx + 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= icpd_pkg::ST_CLEAR;
            epoch_reg    <= '0;
            clr_addr_reg <= '0;
            go_reg       <= 1'b0;
            pos_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            epoch_reg    <= epoch_next;
            clr_addr_reg <= clr_addr_next;
            go_reg       <= go_next;
            pos_reg      <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg <= rank_next;
        n_reg    <= n_next;
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        step_reg <= step_next;
        v_reg    <= v_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        epoch_next    = epoch_reg;
        clr_addr_next = clr_addr_reg;
        go_next       = go_reg;
        pos_next      = pos_reg;
        rank_next     = rank_reg;
        n_next        = n_reg;
        x_next        = x_reg;
        acc_next      = acc_reg;
        step_next     = step_reg;
        v_next        = v_reg;
        res_next      = res_reg;
        mem_we        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_wdata     = {epoch_reg, clr_low};
        mem_raddr     = '0;
        din.ready     = 1'b0;
        res_valid     = 1'b0;

        case (state_reg)
            icpd_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_addr_next = '0;
                    go_next       = 1'b0;
                    state_next    = go_reg ? icpd_pkg::ST_DESC : icpd_pkg::ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            icpd_pkg::ST_IDLE:
            begin
                din.ready = 1'b1;
                if (din.valid)
                begin
                    rank_next  = din.rank;
                    n_next     = eff_n;
                    x_next     = '0;
                    acc_next   = '0;
                    step_next  = TOP_STEP;
                    state_next = icpd_pkg::ST_DESC;
                    if (din.start_req)
                    begin
                        pos_next = '0;
                        if (epoch_reg == EPOCH_MAX)
                        begin
                            epoch_next = '0;
                            go_next    = 1'b1;
                            state_next = icpd_pkg::ST_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                    end
                end
            end

            icpd_pkg::ST_DESC:
            begin
                if (step_reg == '0)
                begin
                    if (v_bad)
                    begin
                        res_next.element  = '0;
                        res_next.last     = 1'b0;
                        res_next.bad_rank = 1'b1;
                        state_next        = icpd_pkg::ST_OUT;
                    end
                    else
                    begin
                        mem_raddr         = AW'(x_reg);
                        v_next            = v_cand;
                        pos_next          = pos_inc;
                        res_next.element  = ELW'(v_cand);
                        res_next.last     = is_last;
                        res_next.bad_rank = 1'b0;
                        state_next        = icpd_pkg::ST_REM;
                    end
                end
                else if (nx <= n_reg)
                begin
                    mem_raddr  = AW'(nx - 1'b1);
                    state_next = icpd_pkg::ST_DCHK;
                end
                else
                begin
                    step_next = step_reg >> 1;
                end
            end

            icpd_pkg::ST_DCHK:
            begin
                if (take)
                begin
                    x_next   = nx;
                    acc_next = LW'(sum);
                end
                step_next  = step_reg >> 1;
                state_next = icpd_pkg::ST_DESC;
            end

            icpd_pkg::ST_REM:
            begin
                // write back the decremented count while reading the parent
                mem_we    = 1'b1;
                mem_waddr = AW'(v_reg - 1'b1);
                mem_wdata = {epoch_reg, rd_val - 1'b1};
                if (v_step <= MAX_V)
                begin
                    mem_raddr = AW'(v_step - 1'b1);
                    v_next    = v_step;
                end
                else
                begin
                    state_next = icpd_pkg::ST_OUT;
                end
            end

            icpd_pkg::ST_OUT:
            begin
                res_valid = 1'b1;
                if (res_free)
                begin
                    state_next = icpd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = icpd_pkg::ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

// ===== sv/inverse_cantor_permutation_decoder.sv =====
// ----------------------------------------------------------------------------
// inverse_cantor_permutation_decoder
// lehmer code digits in, permutation elements of 1..n out
// ----------------------------------------------------------------------------
// each input beat carries one lehmer digit (a zero-based rank among the values
// of 1..n not yet used) and returns exactly one output beat with the value at
// that rank, which is then marked used. a beat with start_req set first puts
// all values back. n comes from perm_length (reset 1, saturated at
// MAX_LENGTH) and should only be written while the block is idle. the unused
// values are counted in a fenwick tree held in one simple dual port memory of
// MAX_LENGTH words; a digit goes through a descent (one memory read and one
// compare per tree level, L = clog2(MAX_LENGTH+1) levels, then the range
// check), a read-modify-write removal up the tree and a handoff to the
// output register. a start only bumps a 6-bit epoch tag; after reset and on
// every 64th start a sweep over all MAX_LENGTH words rewrites the memory,
// with the input held off. a rank at or above the remaining count returns
// element 0 with bad_rank set and removes nothing. an output register lets
// the next digit be taken while a result still waits.
// ----------------------------------------------------------------------------
module inverse_cantor_permutation_decoder #(
    parameter int MAX_LENGTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    icpd_in_if.sink                    din,
    icpd_out_if.source                 dout,
    input  logic                       cfg_we,
    input  logic [icpd_pkg::LEN_W-1:0] cfg_wdata
);

    localparam int AW   = $clog2(MAX_LENGTH);
    localparam int LW   = $clog2(MAX_LENGTH + 1);
    localparam int DW   = icpd_pkg::EPOCH_W + LW;
    localparam int LENW = icpd_pkg::LEN_W;

    // permutation length register
    logic [LENW-1:0] perm_length_reg;

    // tree memory port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;

    // result handoff from the sequencer
    logic              res_valid;
    logic              res_free;
    icpd_pkg::result_t res;

    // output register
    logic              out_valid_reg;
    icpd_pkg::result_t out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_length_reg <= LENW'(1);
        end
        else if (cfg_we)
        begin
            perm_length_reg <= cfg_wdata;
        end
    end

    icpd_tree_ram #(
        .DEPTH (MAX_LENGTH),
        .DW    (DW)
    ) u_tree_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    icpd_ctrl #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .perm_length (perm_length_reg),
        .din         (din),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .res_valid   (res_valid),
        .res         (res),
        .res_free    (res_free)
    );

    // the register takes a new result when empty or drained in this cycle
    assign res_free = !out_valid_reg || dout.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_free)
        begin
            out_res_reg <= res;
        end
    end

    assign dout.valid    = out_valid_reg;
    assign dout.element  = out_res_reg.element;
    assign dout.last     = out_res_reg.last;
    assign dout.bad_rank = out_res_reg.bad_rank;

endmodule

// ===== test/tb_inverse_cantor_permutation_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_inverse_cantor_permutation_decoder
// self-checking bench for the lehmer code to permutation decoder
// ----------------------------------------------------------------------------
// a short table of directed digits (reset state, length extremes, saturated
// length, bad ranks, too many digits, length changed mid-permutation) is
// followed by phases of random permutations at changing lengths, with some
// noise and broken sequences mixed in. every accepted digit runs through a
// fenwick tree predictor kept here and every output beat is compared field
// by field with the oldest expected element. both sides idle in random
// bursts, and once the sink holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_inverse_cantor_permutation_decoder;

    localparam int LEN_W  = icpd_pkg::LEN_W;
    localparam int RANK_W = icpd_pkg::RANK_W;
    localparam int ELEM_W = icpd_pkg::ELEM_W;

    typedef icpd_pkg::result_t result_t;

    localparam int MAX_LEN        = 1024;
    localparam int DESCENT_TOP    = 21;     // highest bit tried by the descent
    localparam int CNT_MAX        = 2047;   // saturation of the position count
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 40;     // margin before a length write
    localparam int TAIL_CYCLES    = 80;     // quiet time after the last beat
    localparam int WATCHDOG_LIMIT = 12000;  // clearing sweep + hold-off, many times over
    localparam int PRESSURE_AT    = 150;    // output beats before the long hold-off
    localparam int PRESSURE_LEN   = 400;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 65;
    localparam int CALM_PHASES    = 2;      // last phases run without idling
    localparam int MAX_PRINTS     = 200;

    localparam logic TYPED = 1'b1;
    localparam logic PRED  = 1'b0;

    // one directed digit: length to run at, the beat itself, and an
    // expected element where it is plain enough to write down
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic              start;
        logic [RANK_W-1:0] rank;
        logic              typed;
        result_t           res;
    } dir_row_t;

    localparam int NUM_DIR = 24;
    localparam dir_row_t DIR_TAB [NUM_DIR] = '{
        // reset length 1, tree full: the single value comes out as the last
        '{11'd1,    1'b0, 10'd0,    TYPED, '{11'd1,    1'b1, 1'b0}},
        // nothing left without a start
        '{11'd1,    1'b0, 10'd0,    TYPED, '{11'd0,    1'b0, 1'b1}},
        '{11'd1,    1'b1, 10'd1023, TYPED, '{11'd0,    1'b0, 1'b1}},
        '{11'd1,    1'b1, 10'd0,    TYPED, '{11'd1,    1'b1, 1'b0}},
        // length zero, every rank is out of range
        '{11'd0,    1'b1, 10'd0,    TYPED, '{11'd0,    1'b0, 1'b1}},
        '{11'd0,    1'b0, 10'd1023, TYPED, '{11'd0,    1'b0, 1'b1}},
        // full length, highest rank picks the top value
        '{11'd1024, 1'b1, 10'd1023, TYPED, '{11'd1024, 1'b0, 1'b0}},
        '{11'd1024, 1'b0, 10'd1023, TYPED, '{11'd0,    1'b0, 1'b1}},
        '{11'd1024, 1'b0, 10'd0,    TYPED, '{11'd1,    1'b0, 1'b0}},
        '{11'd1024, 1'b0, 10'd511,  PRED,  '0},
        // length above the maximum saturates
        '{11'd2047, 1'b1, 10'd1023, TYPED, '{11'd1024, 1'b0, 1'b0}},
        '{11'd2047, 1'b0, 10'd600,  PRED,  '0},
        // a full permutation of three, then one digit too many
        '{11'd3,    1'b1, 10'd2,    TYPED, '{11'd3,    1'b0, 1'b0}},
        '{11'd3,    1'b0, 10'd1,    TYPED, '{11'd2,    1'b0, 1'b0}},
        '{11'd3,    1'b0, 10'd0,    TYPED, '{11'd1,    1'b1, 1'b0}},
        '{11'd3,    1'b0, 10'd0,    TYPED, '{11'd0,    1'b0, 1'b1}},
        // length changed in the middle of a permutation
        '{11'd6,    1'b1, 10'd2,    PRED,  '0},
        '{11'd6,    1'b0, 10'd4,    PRED,  '0},
        '{11'd2,    1'b0, 10'd0,    PRED,  '0},
        '{11'd2,    1'b0, 10'd1,    PRED,  '0},
        '{11'd5,    1'b0, 10'd1,    PRED,  '0},
        // one below the maximum
        '{11'd1023, 1'b1, 10'd1022, TYPED, '{11'd1023, 1'b0, 1'b0}},
        '{11'd1023, 1'b0, 10'd1022, TYPED, '{11'd0,    1'b0, 1'b1}},
        '{11'd1023, 1'b0, 10'd682,  PRED,  '0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    icpd_in_if  din_if ();
    icpd_out_if dout_if ();

    inverse_cantor_permutation_decoder #(
        .MAX_LENGTH (MAX_LEN)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din_if),
        .dout      (dout_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // predictor state: fenwick counts of unused values, elements emitted
    // since the last start, and the length register as last written
    logic [ELEM_W-1:0] free_tree [1:MAX_LEN];
    logic [LEN_W-1:0]  emitted_cnt;
    logic [LEN_W-1:0]  length_reg;

    result_t     pending_elems [$];
    int unsigned err_count;
    int unsigned out_beats;
    int unsigned quiet_cycles;
    int unsigned cur_len;       // length as programmed by the stimulus side
    bit          idle_on;

    // expectation typed into the directed table, travels with the beat
    logic        typed_has;
    result_t     typed_res;

    function automatic void refill_tree();
        for (int i = 1; i <= MAX_LEN; i++)
            free_tree[i] = ELEM_W'(i & (~i + 1));
        emitted_cnt = '0;
    endfunction

    // decode one digit against the predictor tree and update it
    function automatic result_t decode_digit(input logic start, input logic [RANK_W-1:0] rank);
        int unsigned n;
        int unsigned x;
        int unsigned acc;
        int unsigned nx;
        int unsigned v;
        int unsigned w;
        result_t     res;
        n = (length_reg > MAX_LEN) ? MAX_LEN : length_reg;
        if (start)
            refill_tree();
        x   = 0;
        acc = 0;
        // binary lifting: largest prefix whose count stays within the rank
        for (int b = DESCENT_TOP; b >= 0; b--)
        begin
            nx = x + (1 << b);
            if (nx <= n && acc + free_tree[nx] <= rank)
            begin
                x   = nx;
                acc = acc + free_tree[nx];
            end
        end
        v = x + 1;
        if (v > n)
        begin
            // bad rank: nothing removed, count untouched
            res.element  = '0;
            res.last     = 1'b0;
            res.bad_rank = 1'b1;
            return res;
        end
        // remove the value over the whole tree, not just 1..n
        w = v;
        while (w <= MAX_LEN)
        begin
            free_tree[w] = free_tree[w] - 1'b1;
            w = w + (w & (~w + 1));
        end
        if (emitted_cnt < CNT_MAX)
            emitted_cnt = emitted_cnt + 1'b1;
        res.element  = ELEM_W'(v);
        res.last     = (emitted_cnt == n);
        res.bad_rank = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        // keep the log short, the count still covers every mismatch
        if (err_count < MAX_PRINTS)
            $display("mismatch on %s at output beat %0d: got %0d, want %0d",
                     field, out_beats, got, want);
        err_count++;
    endtask

    // scoreboard: outputs are checked before the input of the same edge is
    // predicted, since a result never leaves in the edge its digit enters
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (dout_if.valid && dout_if.ready)
            begin
                got.element  = dout_if.element;
                got.last     = dout_if.last;
                got.bad_rank = dout_if.bad_rank;
                if (pending_elems.size() == 0)
                    report_mismatch("unexpected beat, element", got.element, 0);
                else
                begin
                    want = pending_elems.pop_front();
                    if (got.element !== want.element)
                        report_mismatch("element", got.element, want.element);
                    if (got.last !== want.last)
                        report_mismatch("last", got.last, want.last);
                    if (got.bad_rank !== want.bad_rank)
                        report_mismatch("bad_rank", got.bad_rank, want.bad_rank);
                end
                out_beats++;
            end
            if (din_if.valid && din_if.ready)
            begin
                // the predictor always runs so its tree stays in step
                want = decode_digit(din_if.start_req, din_if.rank);
                if (typed_has)
                    pending_elems.push_back(typed_res);
                else
                    pending_elems.push_back(want);
            end
            if (cfg_we)
                length_reg = cfg_wdata;
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_inverse_cantor_permutation_decoder: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // sink side: random idle bursts, one long hold-off to back up the block
    initial
    begin
        bit          held;
        int unsigned gap;
        held = 1'b0;
        dout_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held && out_beats >= PRESSURE_AT)
            begin
                held = 1'b1;
                dout_if.ready <= 1'b0;
                repeat (PRESSURE_LEN - 1) @(negedge clk);
            end
            else if (idle_on && $urandom_range(5, 0) == 0)
            begin
                gap = $urandom_range(15, 1);
                dout_if.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                dout_if.ready <= 1'b1;
        end
    end

    // offer one digit from a falling edge and return at the falling edge
    // after it was taken, valid still high so the next beat can follow
    task automatic send_digit(input logic start, input logic [RANK_W-1:0] rank,
                              input logic has_typed, input result_t res);
        int unsigned gap;
        if (idle_on && $urandom_range(3, 0) == 0)
        begin
            gap = $urandom_range(15, 1);
            din_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        din_if.valid     <= 1'b1;
        din_if.start_req <= start;
        din_if.rank      <= rank;
        typed_has        <= has_typed;
        typed_res        <= res;
        do
            @(posedge clk);
        while (!din_if.ready);
        @(negedge clk);
    endtask

    // stop offering and wait until every expected element has come out
    task automatic drain(input int unsigned extra);
        din_if.valid <= 1'b0;
        while (pending_elems.size() != 0)
            @(posedge clk);
        repeat (extra) @(negedge clk);
    endtask

    // length register is only written with the block idle
    task automatic set_length(input int unsigned len);
        drain(SETTLE_CYCLES);
        cfg_we    <= 1'b1;
        cfg_wdata <= LEN_W'(len);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_len = len;
    endtask

    // mostly well-formed permutations with random digits; long lengths are
    // cut short and restarted, with noise, early restarts and extra digits
    task automatic run_random_phase(input int unsigned len, input int unsigned budget);
        int unsigned n;
        int unsigned k;
        int unsigned cap;
        int unsigned pick;
        logic        start;
        logic [RANK_W-1:0] rank;
        set_length(len);
        n   = (len > MAX_LEN) ? MAX_LEN : len;
        k   = 0;
        cap = 0;
        for (int unsigned sent = 0; sent < budget; sent++)
        begin
            if (k == 0 || k >= cap)
            begin
                start = 1'b1;
                k     = 0;
                // short lengths run to the end, now and then one digit over
                cap = (n > 32) ? $urandom_range(24, 4)
                               : n + ($urandom_range(3, 0) == 0);
            end
            else
                start = 1'b0;
            if (k < n)
                rank = RANK_W'($urandom_range(n - k - 1, 0));
            else
                rank = RANK_W'($urandom_range(MAX_LEN - 1, 0));
            pick = $urandom_range(19, 0);
            if (pick == 0)
                rank = RANK_W'($urandom_range(MAX_LEN - 1, 0));
            else if (pick == 1 && k > 0)
            begin
                // restart in the middle of a permutation
                start = 1'b1;
                k     = 0;
            end
            send_digit(start, rank, PRED, '0);
            k++;
        end
    endtask

    // stimulus
    initial
    begin
        int unsigned len;
        int unsigned pick;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        din_if.valid     <= 1'b0;
        din_if.start_req <= 1'b0;
        din_if.rank      <= '0;
        typed_has        <= 1'b0;
        typed_res        <= '0;
        err_count   = 0;
        out_beats   = 0;
        idle_on     = 1'b1;
        length_reg  = LEN_W'(1);
        cur_len     = 1;
        refill_tree();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int i = 0; i < NUM_DIR; i++)
        begin
            if (DIR_TAB[i].len != cur_len)
                set_length(DIR_TAB[i].len);
            send_digit(DIR_TAB[i].start, DIR_TAB[i].rank, DIR_TAB[i].typed, DIR_TAB[i].res);
        end

        // random phases, fixed extremes first, then mostly short lengths
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            idle_on = (ph < NUM_PHASES - CALM_PHASES) ? ($urandom_range(3, 0) != 0) : 1'b0;
            pick = $urandom_range(19, 0);
            case (ph)
                0:       len = 1;
                1:       len = MAX_LEN;
                2:       len = CNT_MAX;
                3:       len = 0;
                default:
                begin
                    if (pick < 12)
                        len = $urandom_range(12, 2);
                    else if (pick < 17)
                        len = $urandom_range(64, 13);
                    else
                        len = $urandom_range(CNT_MAX, 0);
                end
            endcase
            run_random_phase(len, (ph == 3) ? 10 : PHASE_ITEMS);
        end

        drain(0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb_inverse_cantor_permutation_decoder: done, clean");
        else
            $display("tb_inverse_cantor_permutation_decoder: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/icpd_pkg.sv
sv/icpd_in_if.sv
sv/icpd_out_if.sv
sv/icpd_tree_ram.sv
sv/icpd_ctrl.sv
sv/inverse_cantor_permutation_decoder.sv
test/tb_inverse_cantor_permutation_decoder.sv
